@@ src/software_timer_bank_macros.svh @@
// Assertion macros shared by the timer bank RTL.
`ifndef SOFTWARE_TIMER_BANK_MACROS_SVH
`define SOFTWARE_TIMER_BANK_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define STB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("software_timer_bank: assertion failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define STB_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("software_timer_bank: assertion failed");

`endif

@@ src/stb_pkg.sv @@
// Types and constants for the software timer bank.
package stb_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int RES_W       = 5;
    localparam logic [RES_W-1:0] RES_MAX = RES_W'(MAX_RESULTS);

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_SETUP = 3'd1,
        CMD_ARM   = 3'd2,
        CMD_START = 3'd3,
        CMD_STOP  = 3'd4,
        CMD_CHECK = 3'd5,
        CMD_QUERY = 3'd6
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_RD,
        ST_EVAL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  timer_id;
        logic [31:0] ticks;
        logic        periodic;
    } t_in_item;

    typedef struct packed {
        logic [3:0] result_timer;
        logic       fired;
        logic       stopped;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [31:0] period;
        logic [31:0] deadline;
    } t_entry;

endpackage

@@ src/stb_alu.sv @@
// Shared tick adder and deadline comparator.
module stb_alu
    import stb_pkg::*;
(
    input  logic [31:0] i_now,
    input  logic [31:0] i_add_b,
    input  logic [31:0] i_cmp_b,
    output logic [31:0] o_sum,
    output logic        o_ge
);

    assign o_sum = i_now + i_add_b;
    assign o_ge  = (i_now >= i_cmp_b);

endmodule

@@ src/stb_tmem.sv @@
// Period/deadline memory with per-entry valid bits; unwritten entries read as zero.
module stb_tmem
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = 16,
    parameter int IDX_W      = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_entry           i_wr_data,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_entry           o_rd_data
);

    t_entry                  mem [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]   r_valid;
    t_entry                  r_rd_data;
    logic                    r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data  <= mem[i_rd_addr];
        r_rd_valid <= r_valid[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

@@ src/software_timer_bank.sv @@
// Top level of the software timer bank: command sequencer, timer flags and result register.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one command transaction
// at a time; o_in_ready is high only while the sequencer is idle.
// Output channel (o_out_valid / i_out_ready / o_out_data) carries result transactions
// from a single output register; a query gives one, a check gives one per fired
// timer (last marks the final one) or one with fired = 0 when none fire.
// Sequence: each command is accepted in idle, then executed. A query result appears
// in the register in the cycle after execute. A check scans timers through the shared
// adder/comparator, each timer passing a memory read state and an evaluate state, and
// ends early if 16 timers fire first.
// A fired timer is held back until the next one is found so that last can be set;
// if the output register is still full, the scan waits on that timer.
// Reset (synchronous, active low) zeroes the tick counter and marks all timers
// inactive, one-shot, with zero period and deadline; no clearing pass is needed.
// A stalled receiver only stalls the sequencer; no transaction is dropped.
`include "software_timer_bank_macros.svh"

module software_timer_bank
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W = $clog2(NUM_TIMERS + 1);
    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(NUM_TIMERS);
    localparam logic [6:0] NUM_TIMERS_W7 = 7'(NUM_TIMERS);

    t_state                r_state, n_state;
    t_in_item              r_cmd, n_cmd;
    logic [31:0]           r_now, n_now;
    logic [NUM_TIMERS-1:0] r_active, n_active;
    logic [NUM_TIMERS-1:0] r_periodic, n_periodic;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic [RES_W-1:0]      r_count, n_count;
    logic                  r_hold_valid, n_hold_valid;
    logic [3:0]            r_hold_timer, n_hold_timer;
    logic                  r_out_valid;
    t_out_item             r_out_data;

    logic                  out_free;
    logic                  out_load;
    t_out_item             out_next;
    logic                  cmd_ok;
    logic [IDX_W-1:0]      cmd_idx;
    logic [IDX_W-1:0]      scan_idx;
    logic                  eval_fire;
    logic                  mem_wr_en;
    logic [IDX_W-1:0]      mem_wr_addr;
    t_entry                mem_wr_data;
    t_entry                mem_rd_data;
    logic [31:0]           alu_add_b;
    logic [31:0]           alu_sum;
    logic                  alu_ge;
    logic                  hold_stall;
    logic                  done_load;

    assign out_free  = !r_out_valid || i_out_ready;
    assign cmd_ok    = (7'(r_cmd.timer_id) < NUM_TIMERS_W7);
    assign cmd_idx   = IDX_W'(r_cmd.timer_id);
    assign scan_idx  = r_idx[IDX_W-1:0];
    assign eval_fire = r_active[scan_idx] && alu_ge;
    assign alu_add_b = (r_state == ST_EVAL) ? mem_rd_data.period :
                       (r_cmd.command == CMD_TICK) ? 32'd1 : r_cmd.ticks;

    stb_alu u_alu (
        .i_now   (r_now),
        .i_add_b (alu_add_b),
        .i_cmp_b (mem_rd_data.deadline),
        .o_sum   (alu_sum),
        .o_ge    (alu_ge)
    );

    stb_tmem #(
        .NUM_TIMERS (NUM_TIMERS),
        .IDX_W      (IDX_W)
    ) u_tmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (scan_idx),
        .o_rd_data (mem_rd_data)
    );

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_now        = r_now;
        n_active     = r_active;
        n_periodic   = r_periodic;
        n_idx        = r_idx;
        n_count      = r_count;
        n_hold_valid = r_hold_valid;
        n_hold_timer = r_hold_timer;
        out_load     = 1'b0;
        out_next     = '0;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = cmd_idx;
        mem_wr_data  = '{period: r_cmd.ticks, deadline: alu_sum};
        o_in_ready   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_cmd   = i_in_data;
                    n_state = ST_CMD;
                end
            end
            ST_CMD: begin
                n_state = ST_IDLE;
                case (t_cmd'(r_cmd.command))
                    CMD_TICK: begin
                        n_now = alu_sum;
                    end
                    CMD_SETUP, CMD_ARM: begin
                        if (cmd_ok) begin
                            mem_wr_en           = 1'b1;
                            n_periodic[cmd_idx] = r_cmd.periodic;
                            n_active[cmd_idx]   = (r_cmd.command == CMD_ARM);
                        end
                    end
                    CMD_START: begin
                        if (cmd_ok) begin
                            n_active[cmd_idx] = 1'b1;
                        end
                    end
                    CMD_STOP: begin
                        if (cmd_ok) begin
                            n_active[cmd_idx] = 1'b0;
                        end
                    end
                    CMD_QUERY: begin
                        if (out_free) begin
                            out_load              = 1'b1;
                            out_next.result_timer = r_cmd.timer_id;
                            out_next.stopped      = cmd_ok ? !r_active[cmd_idx] : 1'b1;
                            out_next.last         = 1'b1;
                        end else begin
                            n_state = ST_CMD;
                        end
                    end
                    CMD_CHECK: begin
                        n_idx        = '0;
                        n_count      = '0;
                        n_hold_valid = 1'b0;
                        n_state      = ST_RD;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_RD: begin
                if (r_idx == SCAN_END || r_count == RES_MAX) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!eval_fire) begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = ST_RD;
                end else if (!r_hold_valid || out_free) begin
                    if (r_hold_valid) begin
                        out_load              = 1'b1;
                        out_next.result_timer = r_hold_timer;
                        out_next.fired        = 1'b1;
                    end
                    n_hold_valid = 1'b1;
                    n_hold_timer = 4'(r_idx);
                    n_count      = r_count + RES_W'(1);
                    if (r_periodic[scan_idx]) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = scan_idx;
                        mem_wr_data = '{period: mem_rd_data.period, deadline: alu_sum};
                    end else begin
                        n_active[scan_idx] = 1'b0;
                    end
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = ST_RD;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load              = 1'b1;
                    out_next.result_timer = r_hold_valid ? r_hold_timer : 4'd0;
                    out_next.fired        = r_hold_valid;
                    out_next.last         = 1'b1;
                    n_state               = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_now        <= '0;
            r_active     <= '0;
            r_periodic   <= '0;
            r_idx        <= '0;
            r_count      <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_now        <= n_now;
            r_active     <= n_active;
            r_periodic   <= n_periodic;
            r_idx        <= n_idx;
            r_count      <= n_count;
            r_hold_valid <= n_hold_valid;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_hold_timer <= n_hold_timer;
        if (out_load) begin
            r_out_data <= out_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign hold_stall = (r_state == ST_EVAL) && eval_fire && r_hold_valid && !out_free;
    assign done_load  = (r_state == ST_DONE) && out_free;

    `STB_ASSERT_IMP(a_count_cap, 1'b1, r_count <= RES_MAX)
    `STB_ASSERT_NXT(a_hold_stall, hold_stall, r_state == ST_EVAL)
    `STB_ASSERT_IMP(a_wr_state, mem_wr_en, r_state == ST_CMD || r_state == ST_EVAL)
    `STB_ASSERT_NXT(a_done_exit, done_load, r_state == ST_IDLE && o_out_valid && o_out_data.last)

endmodule
